[sv/crcg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package crcg_pkg;
   localparam int DW = 33;   // magnitude of a coordinate difference
   localparam int SW = 67;   // sum of three squares
   localparam int RW = 34;   // root width
   localparam int QW = 17;   // normal magnitude width
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic          rod;
      logic [9:0]    tag;
      logic [DW-1:0] mx;
      logic [DW-1:0] my;
      logic [DW-1:0] mz;
      logic          sx;
      logic          sy;
      logic          sz;
      logic [31:0]   rest;
      logic [16:0]   bnc;
   } link_type;

   // root-finding cell state
   typedef struct packed {
      logic          vld;
      link_type      lk;
      logic [SW-1:0] rem;
      logic [RW-1:0] root;
   } sq_type;

   // divide cell state: three parallel restoring quotients
   typedef struct packed {
      logic          vld;
      logic          emit;
      logic          flip;
      logic [9:0]    tag;
      logic [31:0]   pen;
      logic [16:0]   bnc;
      logic [RW-1:0] dlen;
      logic [RW+1:0] rx;
      logic [RW+1:0] ry;
      logic [RW+1:0] rz;
      logic [DW+16:0] nx;
      logic [DW+16:0] ny;
      logic [DW+16:0] nz;
      logic [QW+32:0] qx;
      logic [QW+32:0] qy;
      logic [QW+32:0] qz;
      logic          sx;
      logic          sy;
      logic          sz;
   } dv_type;
endpackage
`default_nettype wire

[sv/cable_rod_contact_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 1 entry register, 34 root cells, 1 decide stage, 50 divide cells,
//   1 output register.
// Throughput: one link per cycle while the result side does not stall; the whole cell chain advances together.
// A stall at the result side freezes the chain; ready follows the output slot.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module cable_rod_contact_generator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: link_tag[9:0], first_x, first_y, first_z, second_x, second_y,
   //        second_z, rest_length, bounce[16:0], zero fill to 256 bits
   input  wire logic [255:0] req_tdata,
   // tuser: mode
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: contact_tag[9:0], normal_x, normal_y, normal_z (18 each),
   //        penetration[31:0], contact_bounce[16:0], zero fill to 120 bits
   output logic [119:0]      rsp_tdata
);
   import crcg_pkg::*;
   localparam int NSQ = RW;
   localparam int NDV = QW + 33;

   logic adv;
   sq_type sq [NSQ+1];
   dv_type dv [NDV+1];
   logic [119:0] out_ff;
   logic         ov_ff;

   // chain moves when the output slot is free or being drained
   assign adv        = !ov_ff || rsp_tready;
   assign req_tready = adv;

   // entry: form difference magnitudes (second point minus first point)
   logic signed [32:0] ddx, ddy, ddz;
   logic [DW-1:0] ax, ay, az;
   always_comb begin
      ddx = 33'(signed'(req_tdata[137:106])) - 33'(signed'(req_tdata[41:10]));
      ddy = 33'(signed'(req_tdata[169:138])) - 33'(signed'(req_tdata[73:42]));
      ddz = 33'(signed'(req_tdata[201:170])) - 33'(signed'(req_tdata[105:74]));
      ax  = ddx[32] ? DW'(-ddx) : DW'(ddx);
      ay  = ddy[32] ? DW'(-ddy) : DW'(ddy);
      az  = ddz[32] ? DW'(-ddz) : DW'(ddz);
   end
   // squares and their sum registered at entry (one 33x33 per axis)
   sq_type ent_ff;
   logic [2*DW-1:0] px, py, pz;
   always_comb begin
      px = ax * ax;
      py = ay * ay;
      pz = az * az;
   end
   always_ff @(posedge clock) begin
      if (reset) ent_ff.vld <= 1'b0;
      else if (adv) ent_ff.vld <= req_tvalid;
      if (adv) begin
         ent_ff.lk.rod  <= req_tuser;
         ent_ff.lk.tag  <= req_tdata[9:0];
         ent_ff.lk.mx   <= ax;
         ent_ff.lk.my   <= ay;
         ent_ff.lk.mz   <= az;
         ent_ff.lk.sx   <= ddx[32];
         ent_ff.lk.sy   <= ddy[32];
         ent_ff.lk.sz   <= ddz[32];
         ent_ff.lk.rest <= req_tdata[233:202];
         ent_ff.lk.bnc  <= req_tdata[250:234];
         ent_ff.rem     <= SW'(px) + SW'(py) + SW'(pz);
         ent_ff.root    <= '0;
      end
   end
   assign sq[0] = ent_ff;

   // root cells, most significant bit first
   for (genvar i = 0; i < NSQ; i++) begin : g_sq
      crcg_sqrt_cell #(.BIT(NSQ - 1 - i)) u_cell (
         .clock(clock), .reset(reset), .adv(adv), .din(sq[i]), .dout(sq[i+1]));
   end

   // decide: emit, penetration, flip, bounce; seed the divide chain
   dv_type dec_ff;
   always_ff @(posedge clock) begin
      logic [RW-1:0] d;
      logic [RW:0]   p;
      logic          e, f;
      logic [16:0]   b;
      d = sq[NSQ].root;
      f = 1'b0;
      b = sq[NSQ].lk.bnc > ONE_Q16 ? ONE_Q16 : sq[NSQ].lk.bnc;
      if (!sq[NSQ].lk.rod) begin
         e = d >= RW'(sq[NSQ].lk.rest);
         p = {1'b0, d} - (RW+1)'(sq[NSQ].lk.rest);
      end else begin
         e = d != RW'(sq[NSQ].lk.rest);
         b = '0;
         if (d > RW'(sq[NSQ].lk.rest)) p = {1'b0, d} - (RW+1)'(sq[NSQ].lk.rest);
         else begin
            p = (RW+1)'(sq[NSQ].lk.rest) - {1'b0, d};
            f = 1'b1;
         end
      end
      if (reset) dec_ff.vld <= 1'b0;
      else if (adv) dec_ff.vld <= sq[NSQ].vld;
      if (adv) begin
         dec_ff.emit <= e;
         dec_ff.flip <= f;
         dec_ff.tag  <= sq[NSQ].lk.tag;
         dec_ff.pen  <= (p[RW:32] != '0) ? 32'hFFFF_FFFF : p[31:0];
         dec_ff.bnc  <= b;
         dec_ff.dlen <= d;
         dec_ff.rx   <= '0;
         dec_ff.ry   <= '0;
         dec_ff.rz   <= '0;
         dec_ff.nx   <= {sq[NSQ].lk.mx, 16'd0};
         dec_ff.ny   <= {sq[NSQ].lk.my, 16'd0};
         dec_ff.nz   <= {sq[NSQ].lk.mz, 16'd0};
         dec_ff.qx   <= '0;
         dec_ff.qy   <= '0;
         dec_ff.qz   <= '0;
         dec_ff.sx   <= sq[NSQ].lk.sx;
         dec_ff.sy   <= sq[NSQ].lk.sy;
         dec_ff.sz   <= sq[NSQ].lk.sz;
      end
   end
   assign dv[0] = dec_ff;

   // divide cells, one quotient bit each
   for (genvar j = 0; j < NDV; j++) begin : g_dv
      crcg_div_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv), .din(dv[j]), .dout(dv[j+1]));
   end

   // clamp, sign, pack into the output register
   function automatic logic [17:0] comp(input logic [QW+32:0] q, input logic neg,
                                        input logic zd);
      logic [17:0] m;
      begin
         m = (q > (QW+33)'(ONE_Q16)) ? 18'(ONE_Q16) : q[17:0];
         if (zd) m = '0;
         comp = neg ? 18'(-m) : m;
      end
   endfunction
   logic zdist;
   assign zdist = dv[NDV].dlen == '0;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= dv[NDV].vld && dv[NDV].emit;
      if (adv)
         out_ff <= {7'd0, dv[NDV].bnc, dv[NDV].pen,
                    comp(dv[NDV].qz, dv[NDV].sz != dv[NDV].flip, zdist),
                    comp(dv[NDV].qy, dv[NDV].sy != dv[NDV].flip, zdist),
                    comp(dv[NDV].qx, dv[NDV].sx != dv[NDV].flip, zdist),
                    dv[NDV].tag};
   end
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
endmodule
`default_nettype wire

[sv/crcg_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module crcg_sqrt_cell #(
   parameter int BIT = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire crcg_pkg::sq_type din,
   output crcg_pkg::sq_type     dout
);
   import crcg_pkg::*;
   // non-restoring-free digit step: try (2r+2^b)*2^b
   logic [SW-1:0] trial;
   sq_type        nxt_in;
   always_comb begin
      trial  = ({{(SW-RW){1'b0}}, din.root} << (BIT + 1)) + (SW'(1) << (2 * BIT));
      nxt_in = din;
      if (din.rem >= trial) begin
         nxt_in.rem  = din.rem - trial;
         nxt_in.root = din.root | (RW'(1) << BIT);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) dout.vld <= 1'b0;
      else if (adv) dout.vld <= din.vld;
      if (adv) begin
         dout.lk   <= nxt_in.lk;
         dout.rem  <= nxt_in.rem;
         dout.root <= nxt_in.root;
      end
   end
endmodule
`default_nettype wire

[sv/crcg_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module crcg_div_cell (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire crcg_pkg::dv_type din,
   output crcg_pkg::dv_type     dout
);
   import crcg_pkg::*;
   dv_type n;
   function automatic void step(input logic [RW+1:0] r, input logic [DW+16:0] num,
                                input logic [RW-1:0] d, output logic [RW+1:0] ro,
                                output logic [DW+16:0] no, output logic qb);
      logic [RW+1:0] t;
      begin
         t  = {r[RW:0], num[DW+16]};
         no = num << 1;
         if (t >= {2'b00, d}) begin
            ro = t - {2'b00, d};
            qb = 1'b1;
         end else begin
            ro = t;
            qb = 1'b0;
         end
      end
   endfunction
   logic bx, by, bz;
   always_comb begin
      n = din;
      step(din.rx, din.nx, din.dlen, n.rx, n.nx, bx);
      step(din.ry, din.ny, din.dlen, n.ry, n.ny, by);
      step(din.rz, din.nz, din.dlen, n.rz, n.nz, bz);
      n.qx = {din.qx[QW+31:0], bx};
      n.qy = {din.qy[QW+31:0], by};
      n.qz = {din.qz[QW+31:0], bz};
   end
   always_ff @(posedge clock) begin
      if (reset) dout.vld <= 1'b0;
      else if (adv) dout <= n;
   end
endmodule
`default_nettype wire

[sv/crcg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module crcg_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [119:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while chain frozen");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[119:113] == 7'd0)
      else $error("fill bits set");
endmodule
bind cable_rod_contact_generator crcg_checker u_chk (.*);
`default_nettype wire

[verif/tb_cable_rod_contact_generator.sv]
`timescale 1ns / 1ps
module tb_cable_rod_contact_generator;

   // one link as the sender sees it
   typedef struct {
      bit                 rod;
      logic [9:0]         tag;
      logic signed [31:0] ax, ay, az;   // first particle
      logic signed [31:0] bx, by, bz;   // second particle or anchor
      logic [31:0]        rest;
      logic [16:0]        bnc;
   } link_type;

   // one contact as the block returns it
   typedef struct {
      logic [9:0]  tag;
      logic [17:0] nx, ny, nz;
      logic [31:0] pen;
      logic [16:0] bnc;
   } contact_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   // tdata: link_tag, first_x/y/z, second_x/y/z, rest_length, bounce
   logic [255:0] req_tdata = '0;
   // tuser: mode
   logic         req_tuser = 1'b0;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata: contact_tag, normal_x/y/z, penetration, contact_bounce
   wire  [119:0] rsp_tdata;

   contact_type pending_contacts[$];
   int       error_count = 0;
   int       links_sent = 0;
   int       contacts_seen = 0;
   bit       idle_on = 1'b1;      // random bursts of idling on both sides
   int       hold_off_cycles = 0; // long receiver stall requested by a test

   cable_rod_contact_generator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // exact integer distance between the two points, Q16.16 raw
   function automatic logic [33:0] link_distance(link_type lk);
      longint      d[3];
      logic [127:0] mag, sum, cand;
      logic [33:0] root;
      d[0] = longint'(lk.bx) - longint'(lk.ax);
      d[1] = longint'(lk.by) - longint'(lk.ay);
      d[2] = longint'(lk.bz) - longint'(lk.az);
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         mag = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
         sum += mag * mag;
      end
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = 128'(root | (34'd1 << b));
         if (cand * cand <= sum) root = cand[33:0];
      end
      return root;
   endfunction

   // one normal component: truncated ratio, clamped to one, sign applied
   function automatic logic [17:0] normal_part(longint d, logic [33:0] span, bit flip);
      logic [63:0] m, q;
      bit          neg;
      if (span == 0) return '0;
      m = (d < 0) ? 64'(-d) : 64'(d);
      q = (m << 16) / 64'(span);
      if (q > 64'd65536) q = 64'd65536;
      neg = (d < 0) != flip;
      return neg ? 18'(-q) : 18'(q);
   endfunction

   // returns 1 and fills the contact when the link produces one
   function automatic bit predict_contact(link_type lk, output contact_type ct);
      logic [33:0] span;
      logic [34:0] depth;
      bit          flip;
      span = link_distance(lk);
      flip = 1'b0;
      ct.tag = lk.tag;
      if (!lk.rod) begin
         if (span < 34'(lk.rest)) return 1'b0;   // slack cable
         depth = 35'(span) - 35'(lk.rest);
         ct.bnc = (lk.bnc > 17'd65536) ? 17'd65536 : lk.bnc;
      end else begin
         if (span == 34'(lk.rest)) return 1'b0;  // rod at its length
         if (span > 34'(lk.rest)) depth = 35'(span) - 35'(lk.rest);
         else begin
            depth = 35'(lk.rest) - 35'(span);
            flip = 1'b1;
         end
         ct.bnc = '0;
      end
      ct.pen = (depth > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : depth[31:0];
      ct.nx = normal_part(longint'(lk.bx) - longint'(lk.ax), span, flip);
      ct.ny = normal_part(longint'(lk.by) - longint'(lk.ay), span, flip);
      ct.nz = normal_part(longint'(lk.bz) - longint'(lk.az), span, flip);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- driving

   // offer one item, hold it until accepted, then maybe idle
   task automatic send_link(link_type lk);
      contact_type ct;
      req_tuser  = lk.rod;
      req_tdata  = {5'd0, lk.bnc, lk.rest, lk.bz, lk.by, lk.bx,
                    lk.az, lk.ay, lk.ax, lk.tag};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (predict_contact(lk, ct)) pending_contacts.push_back(ct);
      links_sent++;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   // receiver: long hold-off on request, random stall bursts otherwise
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   initial begin
      contact_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            contacts_seen++;
            if (pending_contacts.size() == 0) begin
               report_mismatch("unexpected contact", 64'(rsp_tdata[63:0]), 64'd0);
            end else begin
               want = pending_contacts.pop_front();
               if (rsp_tdata[9:0] !== want.tag)
                  report_mismatch("contact_tag", 64'(rsp_tdata[9:0]), 64'(want.tag));
               if (rsp_tdata[27:10] !== want.nx)
                  report_mismatch("normal_x", 64'(rsp_tdata[27:10]), 64'(want.nx));
               if (rsp_tdata[45:28] !== want.ny)
                  report_mismatch("normal_y", 64'(rsp_tdata[45:28]), 64'(want.ny));
               if (rsp_tdata[63:46] !== want.nz)
                  report_mismatch("normal_z", 64'(rsp_tdata[63:46]), 64'(want.nz));
               if (rsp_tdata[95:64] !== want.pen)
                  report_mismatch("penetration", 64'(rsp_tdata[95:64]), 64'(want.pen));
               if (rsp_tdata[112:96] !== want.bnc)
                  report_mismatch("contact_bounce", 64'(rsp_tdata[112:96]), 64'(want.bnc));
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic link_type make_link(bit rod, logic [9:0] tag,
         int ax, int ay, int az, int bx, int by, int bz,
         logic [31:0] rest, logic [16:0] bnc);
      link_type lk;
      lk.rod = rod; lk.tag = tag;
      lk.ax = ax; lk.ay = ay; lk.az = az;
      lk.bx = bx; lk.by = by; lk.bz = bz;
      lk.rest = rest; lk.bnc = bnc;
      return lk;
   endfunction

   // points close together, rest length near the distance: drives every branch
   function automatic link_type near_link();
      link_type lk;
      logic [33:0] span;
      int          spread;
      spread = 1 << $urandom_range(4, 22);
      lk.rod = 1'($urandom_range(0, 1));
      lk.tag = 10'($urandom);
      lk.ax = $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000;
      lk.ay = $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000;
      lk.az = $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000;
      lk.bx = lk.ax + $signed($urandom_range(0, 2 * spread)) - spread;
      lk.by = lk.ay + $signed($urandom_range(0, 2 * spread)) - spread;
      lk.bz = lk.az + $signed($urandom_range(0, 2 * spread)) - spread;
      lk.bnc = 17'($urandom_range(0, 17'h1FFFF));
      span = link_distance(lk);
      case ($urandom_range(0, 3))
         0: lk.rest = span[31:0];                         // exactly at length
         1: lk.rest = span[31:0] + $urandom_range(1, 5000);
         2: lk.rest = (span > 5000) ? span[31:0] - $urandom_range(1, 5000) : 32'd0;
         default: lk.rest = $urandom;
      endcase
      return lk;
   endfunction

   function automatic link_type wild_link();
      link_type lk;
      lk.rod = 1'($urandom_range(0, 1));
      lk.tag = 10'($urandom);
      lk.ax = $urandom; lk.ay = $urandom; lk.az = $urandom;
      lk.bx = $urandom; lk.by = $urandom; lk.bz = $urandom;
      lk.rest = $urandom;
      lk.bnc = 17'($urandom_range(0, 17'h1FFFF));
      return lk;
   endfunction

   task automatic wait_drain();
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // extremes and the named corner cases
   task automatic test_directed();
      localparam int ONE = 65536;
      send_link(make_link(1'b0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 17'd0));    // zero distance cable
      send_link(make_link(1'b1, 10'd1023, 5, 5, 5, 5, 5, 5, ONE, 17'd99)); // zero distance rod
      send_link(make_link(1'b0, 10'd2, 0, 0, 0, 3 * ONE, 4 * ONE, 0, 6 * ONE, 17'd100)); // slack
      send_link(make_link(1'b1, 10'd3, 0, 0, 0, 3 * ONE, 4 * ONE, 0, 5 * ONE, 17'd0)); // exact
      send_link(make_link(1'b0, 10'd4, 0, 0, 0, 3 * ONE, 4 * ONE, 0, 5 * ONE, 17'd65536));
      send_link(make_link(1'b1, 10'd5, ONE, 0, 0, -2 * ONE, 4 * ONE, 0, 7 * ONE,
                          17'd1));                                        // compressed
      send_link(make_link(1'b1, 10'd6, 0, 0, 0, 0, 0, -9 * ONE, 2 * ONE, 17'd5)); // stretched
      send_link(make_link(1'b0, 10'd7, 0, 0, 0, ONE, ONE, ONE, ONE, 17'h1FFFF)); // bounce > 1
      send_link(make_link(1'b0, 10'd8, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 17'd7)); // saturate
      send_link(make_link(1'b1, 10'd9, 32'h7FFFFFFF, 32'h80000000, 0,
                          32'h80000000, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, 17'd0));
      send_link(make_link(1'b1, 10'd10, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 17'd0));
      send_link(make_link(1'b0, 10'd11, 0, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 17'd3));
      send_link(make_link(1'b0, 10'd12, 0, 0, 0, 0, -1, 0, 0, 17'd65535));
      send_link(make_link(1'b1, 10'd13, 1, 2, 3, 1, 2, 3, 0, 17'd0));
   endtask

   // receiver stalls for a long stretch while links keep coming
   task automatic test_back_pressure();
      link_type lk;
      @(negedge clock);
      hold_off_cycles = 400;
      for (int i = 0; i < 150; i++) begin
         lk = wild_link();
         lk.rod = 1'b1;
         lk.rest = 0;
         send_link(lk);
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) send_link(near_link());
         else send_link(wild_link());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_back_pressure();
      test_random(550);
      idle_on = 1'b0;           // last stretch at full rate
      test_random(200);
      req_tvalid = 1'b0;
      wait_drain();
      $display("sent %0d links, checked %0d contacts", links_sent, contacts_seen);
      $display("covered slack, exact, stretched, compressed, saturated and stalled cases");
      if (error_count == 0 && pending_contacts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
